/* src/raster_2x2_average_binning_core_assert.svh */
// assertion macros shared by the binning core
`ifndef RASTER_2X2_AVERAGE_BINNING_CORE_ASSERT_SVH
`define RASTER_2X2_AVERAGE_BINNING_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RBIN_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbin assertion failed");

// antecedent implies consequent in the next cycle
`define RBIN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbin assertion failed");

`endif

/* src/rbin_pkg.sv */
`default_nettype none

package rbin_pkg;

   localparam int PIXEL_WIDTH = 16;
   localparam int PAIR_WIDTH  = 17;
   localparam int BIN_WIDTH   = 18;
   localparam int DIM_WIDTH   = 13;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;
   typedef logic [PAIR_WIDTH-1:0]  pair_type;
   typedef logic [BIN_WIDTH-1:0]   bin_type;
   typedef logic [DIM_WIDTH-1:0]   dim_type;

   localparam dim_type DIM_RESET = 13'd4096;

   localparam int CSR_INDEX_WIDTH = 1;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_FRAME_WIDTH  = 1'b0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic write;
      logic read;
   } mem_cmd_type;

   typedef struct packed {
      pair_type pair_sum;
      logic     use_above;
      logic     end_of_row;
      logic     end_of_frame;
      logic     error;
   } stage_type;

endpackage

`default_nettype wire

/* src/rbin_channels.sv */
`default_nettype none

interface rbin_req_if;
   logic                valid;
   logic                ready;
   rbin_pkg::pixel_type pixel;
   logic                frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface rbin_rsp_if;
   logic              valid;
   logic              ready;
   rbin_pkg::bin_type binned_value;
   logic              end_of_row;
   logic              end_of_frame;
   logic              error;

   modport source (output valid, output binned_value, output end_of_row,
                   output end_of_frame, output error, input ready);
   modport sink (input valid, input binned_value, input end_of_row,
                 input end_of_frame, input error, output ready);
endinterface

`default_nettype wire

/* src/rbin_line_mem.sv */
`default_nettype none

module rbin_line_mem #(
   parameter int DEPTH      = 2048,
   parameter int ADDR_WIDTH = 11
) (
   input  wire                       clock,
   input  wire rbin_pkg::mem_cmd_type cmd,
   input  wire [ADDR_WIDTH-1:0]      addr,
   input  wire rbin_pkg::pair_type   wdata,
   output rbin_pkg::pair_type        rdata
);

   rbin_pkg::pair_type mem [DEPTH];
   rbin_pkg::pair_type rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[addr] <= wdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* src/rbin_raster_ctrl.sv */
`default_nettype none

module rbin_raster_ctrl #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int ADDR_WIDTH = 11
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     accept,
   input  wire rbin_pkg::pixel_type pixel,
   input  wire                     frame_start,
   input  wire rbin_pkg::dim_type  frame_width,
   input  wire rbin_pkg::dim_type  frame_height,
   output logic                    emit,
   output rbin_pkg::stage_type     stage,
   output rbin_pkg::mem_cmd_type   mem_cmd,
   output logic [ADDR_WIDTH-1:0]   mem_addr,
   output rbin_pkg::pair_type      mem_wdata
);

   localparam int IdxWidth = rbin_pkg::DIM_WIDTH - 1;
   localparam logic [31:0] MaxWidthU  = 32'(MAX_WIDTH);
   localparam logic [31:0] MaxHeightU = 32'(MAX_HEIGHT);
   localparam logic [31:0] LineDepthU = 32'(MAX_WIDTH / 2);

   rbin_pkg::dim_type   col_ff, col_in, row_ff, row_in, col, row;
   rbin_pkg::pixel_type left_ff, left_in;
   logic [rbin_pkg::DIM_WIDTH:0] col_next, row_next;
   logic [IdxWidth-1:0] idx;
   logic [ADDR_WIDTH+IdxWidth-1:0] addr_wide;
   logic geometry_ok, row_end, frame_end, in_range;
   rbin_pkg::pair_type pair_sum;

   always_comb begin
      col = frame_start ? '0 : col_ff;
      row = frame_start ? '0 : row_ff;
      col_next = {1'b0, col} + 1'b1;
      row_next = {1'b0, row} + 1'b1;
      row_end = col_next >= {1'b0, frame_width};
      frame_end = row_end && (row_next >= {1'b0, frame_height});
      geometry_ok = (frame_width != '0) && (frame_height != '0)
                    && (32'(frame_width) <= MaxWidthU) && (32'(frame_height) <= MaxHeightU)
                    && !frame_width[0] && !frame_height[0];
      idx = col[rbin_pkg::DIM_WIDTH-1:1];
      addr_wide = {{ADDR_WIDTH{1'b0}}, idx};
      in_range = 32'(idx) < LineDepthU;
      pair_sum = {1'b0, left_ff} + {1'b0, pixel};
   end

   always_comb begin
      left_in = left_ff;
      col_in = col_ff;
      row_in = row_ff;
      emit = 1'b0;
      mem_cmd = '0;
      stage.pair_sum = pair_sum;
      stage.use_above = 1'b0;
      stage.end_of_row = row_end;
      stage.end_of_frame = frame_end;
      stage.error = 1'b0;
      if (accept) begin
         if (geometry_ok) begin
            if (!col[0]) begin
               left_in = pixel;
            end else if (!row[0]) begin
               mem_cmd.write = in_range;
            end else begin
               mem_cmd.read = in_range;
               stage.use_above = in_range;
               emit = 1'b1;
            end
         end else if (frame_end) begin
            emit = 1'b1;
            stage.pair_sum = '0;
            stage.end_of_row = 1'b0;
            stage.error = 1'b1;
         end
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_next[rbin_pkg::DIM_WIDTH-1:0];
         end else begin
            col_in = col_next[rbin_pkg::DIM_WIDTH-1:0];
            row_in = row;
         end
      end
   end

   assign mem_addr = addr_wide[ADDR_WIDTH-1:0];
   assign mem_wdata = pair_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         left_ff <= left_in;
      end
   end

endmodule

`default_nettype wire

/* src/raster_2x2_average_binning_core.sv */
// channel   modport  payload
// req_ch    sink     pixel[15:0], frame_start
// rsp_ch    source   binned_value[17:0], end_of_row, end_of_frame, error
// csr       write    csr_write_enable, csr_index[0:0], csr_write_data[12:0]
//
// one pixel per cycle sustained while rsp_ch does not stall; the result of a pixel is held
// in the stage register (line store read at the accepting edge), then the output register
// line store: one port, at most one access per pixel, registered read data
// reset clears counters and the left pixel, registers go to 4096 x 4096
// rsp_ch stalls back up through a single hold stage to req_ch.ready
`default_nettype none

`include "raster_2x2_average_binning_core_assert.svh"

module raster_2x2_average_binning_core #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                        clock,
   input  wire                        reset,
   rbin_req_if.sink                   req_ch,
   rbin_rsp_if.source                 rsp_ch,
   input  wire                        csr_write_enable,
   input  wire rbin_pkg::csr_index_type csr_index,
   input  wire rbin_pkg::dim_type     csr_write_data
);

   localparam int LineDepth = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
   localparam int AddrWidth = (LineDepth > 1) ? $clog2(LineDepth) : 1;

   rbin_pkg::dim_type width_ff, height_ff;
   logic accept, emit, s1_advance, req_ready;
   logic s1_valid_ff, s1_valid_in, rsp_valid_ff;
   rbin_pkg::stage_type stage, s1_ff;
   rbin_pkg::mem_cmd_type mem_cmd;
   logic [AddrWidth-1:0] mem_addr;
   rbin_pkg::pair_type mem_wdata, mem_rdata, above;
   rbin_pkg::bin_type bin_in, bin_ff;
   logic eor_ff, eof_ff, err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rbin_pkg::DIM_RESET;
         height_ff <= rbin_pkg::DIM_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            rbin_pkg::CSR_FRAME_WIDTH: width_ff <= csr_write_data;
            rbin_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = !s1_valid_ff || s1_advance;
   assign accept = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   rbin_raster_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .ADDR_WIDTH(AddrWidth)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel       (req_ch.pixel),
      .frame_start (req_ch.frame_start),
      .frame_width (width_ff),
      .frame_height(height_ff),
      .emit        (emit),
      .stage       (stage),
      .mem_cmd     (mem_cmd),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata)
   );

   rbin_line_mem #(
      .DEPTH     (LineDepth),
      .ADDR_WIDTH(AddrWidth)
   ) u_line (
      .clock(clock),
      .cmd  (mem_cmd),
      .addr (mem_addr),
      .wdata(mem_wdata),
      .rdata(mem_rdata)
   );

   always_comb begin
      s1_valid_in = req_ready ? (accept && emit) : s1_valid_ff;
      above = s1_ff.use_above ? mem_rdata : '0;
      bin_in = {1'b0, above} + {1'b0, s1_ff.pair_sum};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (s1_advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= stage;
      end
      if (s1_advance && s1_valid_ff) begin
         bin_ff <= bin_in;
         eor_ff <= s1_ff.end_of_row;
         eof_ff <= s1_ff.end_of_frame;
         err_ff <= s1_ff.error;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.binned_value = bin_ff;
   assign rsp_ch.end_of_row = eor_ff;
   assign rsp_ch.end_of_frame = eof_ff;
   assign rsp_ch.error = err_ff;

   `RBIN_ASSERT_SAME(a_error_result, rsp_valid_ff && err_ff, bin_ff == '0 && eof_ff && !eor_ff)
   `RBIN_ASSERT_SAME(a_frame_end_row_end, rsp_valid_ff && eof_ff && !err_ff, eor_ff)
   `RBIN_ASSERT_SAME(a_no_accept_on_stall, s1_valid_ff && !s1_advance, !accept)
   `RBIN_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_ff))
   `RBIN_ASSERT_SAME(a_one_mem_access, 1'b1, !(mem_cmd.write && mem_cmd.read))

endmodule

`default_nettype wire

/* tb/raster_2x2_average_binning_core_tb.sv */
`timescale 1ns / 100ps

module raster_2x2_average_binning_core_tb;

   localparam int MAX_DIM       = 4096;
   localparam int LINE_DEPTH    = MAX_DIM / 2;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      rbin_pkg::bin_type value;
      logic              end_of_row;
      logic              end_of_frame;
      logic              error;
   } bin_result_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_write_enable;
   rbin_pkg::csr_index_type csr_index;
   rbin_pkg::dim_type       csr_write_data;

   rbin_req_if req_ch();
   rbin_rsp_if rsp_ch();

   raster_2x2_average_binning_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;
   int unsigned error_count;

   // binning predictor state
   int unsigned         geo_width;
   int unsigned         geo_height;
   int unsigned         col_pos;
   int unsigned         row_pos;
   rbin_pkg::pixel_type left_pix;
   rbin_pkg::pair_type  pair_sums [LINE_DEPTH];
   bin_result_type      pending_bins [$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("raster_2x2_average_binning_core_tb: FAIL");
      $finish;
   end

   function automatic logic geometry_valid();
      if (geo_width == 0 || geo_height == 0) return 1'b0;
      if (geo_width > MAX_DIM || geo_height > MAX_DIM) return 1'b0;
      return (geo_width[0] == 1'b0) && (geo_height[0] == 1'b0);
   endfunction

   function automatic void predict_bin(input rbin_pkg::pixel_type pix, input logic fs);
      int unsigned    c;
      int unsigned    r;
      int unsigned    idx;
      logic           row_end;
      logic           frame_end;
      logic           ok;
      bin_result_type res;
      ok = geometry_valid();
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      row_end = (c + 1) >= geo_width;
      frame_end = row_end && ((r + 1) >= geo_height);
      idx = c >> 1;
      if (ok) begin
         if (c[0] == 1'b0) begin
            left_pix = pix;
         end else if (r[0] == 1'b0) begin
            if (idx < LINE_DEPTH) pair_sums[idx] = left_pix + pix;
         end else begin
            res.value = ((idx < LINE_DEPTH) ? pair_sums[idx] : rbin_pkg::pair_type'(0))
                        + left_pix + pix;
            res.end_of_row = row_end;
            res.end_of_frame = frame_end;
            res.error = 1'b0;
            pending_bins.push_back(res);
         end
      end else if (frame_end) begin
         res = '0;
         res.end_of_frame = 1'b1;
         res.error = 1'b1;
         pending_bins.push_back(res);
      end
      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
   endtask

   always @(posedge clock) begin
      bin_result_type want;
      if (reset) begin
         geo_width = rbin_pkg::DIM_RESET;
         geo_height = rbin_pkg::DIM_RESET;
         col_pos = 0;
         row_pos = 0;
         left_pix = '0;
         pending_bins.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rbin_pkg::CSR_FRAME_WIDTH:  geo_width = csr_write_data;
               rbin_pkg::CSR_FRAME_HEIGHT: geo_height = csr_write_data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) predict_bin(req_ch.pixel, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_bins.size() == 0) begin
               report_mismatch("result with none pending", rsp_ch.binned_value, 0);
            end else begin
               want = pending_bins.pop_front();
               if (rsp_ch.binned_value !== want.value)
                  report_mismatch("binned_value", rsp_ch.binned_value, want.value);
               if (rsp_ch.end_of_row !== want.end_of_row)
                  report_mismatch("end_of_row", rsp_ch.end_of_row, want.end_of_row);
               if (rsp_ch.end_of_frame !== want.end_of_frame)
                  report_mismatch("end_of_frame", rsp_ch.end_of_frame, want.end_of_frame);
               if (rsp_ch.error !== want.error)
                  report_mismatch("error", rsp_ch.error, want.error);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   function automatic rbin_pkg::pixel_type rand_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return rbin_pkg::pixel_type'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input rbin_pkg::pixel_type pix, input logic fs);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= pix;
      req_ch.frame_start <= fs;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // first pixel carries the restart flag, the rest may carry a stray one
   task automatic send_frame(input int unsigned n_pixels, input logic restart,
                             input int unsigned stray_per_mille);
      for (int unsigned i = 0; i < n_pixels; i++) begin
         send_pixel(rand_pixel(),
                    (i == 0) ? restart : ($urandom_range(999) < stray_per_mille));
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_bins.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= rbin_pkg::CSR_FRAME_WIDTH;
      csr_write_data <= rbin_pkg::dim_type'(w);
      @(negedge clock);
      csr_index <= rbin_pkg::CSR_FRAME_HEIGHT;
      csr_write_data <= rbin_pkg::dim_type'(h);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // default 4096 wide geometry: part of the first row, no results
   task automatic test_reset_geometry();
      send_frame(64, 1'b0, 0);
   endtask

   task automatic test_directed_blocks();
      set_geometry(2, 2);
      repeat (4) send_pixel('1, 1'b0);
      repeat (4) send_pixel('0, 1'b0);
      send_pixel(16'hAAAA, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h8000, 1'b0);
      // restart in the middle of a frame
      send_pixel(16'h1234, 1'b1);
      send_pixel(16'h0FF0, 1'b0);
      send_pixel(16'h00FF, 1'b0);
      send_pixel(16'h0003, 1'b1);
      send_pixel(16'h0004, 1'b0);
      send_pixel(16'h0005, 1'b0);
      send_pixel(16'h0006, 1'b0);
      // width shrunk partway through the first row ends that row early
      set_geometry(8, 2);
      send_frame(5, 1'b1, 0);
      set_geometry(4, 2);
      send_frame(5, 1'b0, 0);
   endtask

   task automatic test_bad_geometry();
      set_geometry(3, 2);
      send_frame(6, 1'b1, 0);
      set_geometry(0, 0);
      send_frame(3, 1'b1, 0);
      set_geometry(2, 1);
      send_frame(2, 1'b1, 0);
      set_geometry(2, 0);
      send_frame(4, 1'b1, 0);
      set_geometry(1, 1);
      send_frame(2, 1'b1, 0);
      set_geometry(8191, 8191);
      send_frame(12, 1'b1, 0);
   endtask

   task automatic test_random_frames(input int unsigned n_items);
      int unsigned sent;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned pick;
      logic        oversized;
      sent = 0;
      w = 2;
      h = 2;
      oversized = 1'b0;
      set_geometry(w, h);
      while (sent < n_items) begin
         if ($urandom_range(1) == 1) begin
            pick = $urandom_range(99);
            oversized = 1'b0;
            if (pick < 80) begin
               w = 2 * $urandom_range(1, 8);
               h = 2 * $urandom_range(1, 4);
            end else if (pick < 95) begin
               w = $urandom_range(0, 9);
               h = $urandom_range(0, 5);
               if (w != 0 && h != 0 && w[0] == 1'b0 && h[0] == 1'b0) w++;
            end else begin
               oversized = 1'b1;
               w = $urandom_range(MAX_DIM + 1, 8191);
               h = $urandom_range(0, 8191);
            end
            set_geometry(w, h);
         end
         if (oversized) n = $urandom_range(1, 30);
         else n = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
         if (!oversized && n > 1 && $urandom_range(9) == 0) n = $urandom_range(1, n - 1);
         send_frame(n, (col_pos == 0 && row_pos == 0) ? 1'($urandom_range(1)) : 1'b1, 3);
         sent += n;
      end
   endtask

   // tallest frame, first rows only
   task automatic test_max_height();
      set_geometry(2, MAX_DIM);
      send_frame(200, 1'b1, 0);
   endtask

   // widest frame, start of the first row only
   task automatic test_max_width();
      set_geometry(MAX_DIM, 2);
      send_frame(64, 1'b1, 0);
   endtask

   initial begin
      error_count = 0;
      src_idle_pct = 30;
      snk_idle_pct = 78;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = rbin_pkg::CSR_FRAME_WIDTH;
      csr_write_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_directed_blocks();
      test_bad_geometry();
      test_random_frames(400);

      src_idle_pct = 78;
      snk_idle_pct = 30;
      test_random_frames(400);
      test_max_height();

      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random_frames(400);
      test_max_width();

      wait_idle();
      if (error_count == 0 && pending_bins.size() == 0) begin
         $display("raster_2x2_average_binning_core_tb: PASS");
      end else begin
         $display("raster_2x2_average_binning_core_tb: FAIL");
      end
      $finish;
   end

endmodule

/* raster_2x2_average_binning_core.f */
+incdir+src
src/rbin_pkg.sv
src/rbin_channels.sv
src/rbin_line_mem.sv
src/rbin_raster_ctrl.sv
src/raster_2x2_average_binning_core.sv
tb/raster_2x2_average_binning_core_tb.sv
